@@ rtl/htt_pkg.sv @@
// Shared types, event and error codes and byte constants of the HTML tag tokenizer.
package htt_pkg;

  localparam int NumEv = 4;
  localparam int IdxW  = $clog2(NumEv);

  typedef enum logic [3:0] {
    EvChar  = 4'd0,
    EvStart = 4'd1,
    EvEnd   = 4'd2,
    EvName  = 4'd3,
    EvAname = 4'd4,
    EvAval  = 4'd5,
    EvClose = 4'd6,
    EvEof   = 4'd7,
    EvErr   = 4'd8
  } ev_kind_e;

  typedef enum logic [3:0] {
    ErrQuestion       = 4'd0,
    ErrInvFirstChar   = 4'd1,
    ErrEofBeforeName  = 4'd2,
    ErrMissingEndName = 4'd3,
    ErrEofInTag       = 4'd4,
    ErrEqBeforeAname  = 4'd5,
    ErrCharInAname    = 4'd6,
    ErrMissingAval    = 4'd7,
    ErrCharInUnqAval  = 4'd8,
    ErrMissingWs      = 4'd9,
    ErrSolidusInTag   = 4'd10,
    ErrEofInComment   = 4'd11
  } err_e;

  localparam logic [3:0] ErrNone = 4'd0;

  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBtick  = 8'h60;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic       new_attr;
    logic       self_close;
    logic [3:0] err;
  } event_t;

  typedef struct packed {
    logic [IdxW-1:0]        last;
    event_t [NumEv-1:0]     ev;
  } entry_t;

endpackage

@@ rtl/htt_front.sv @@
// Front end: accepts bytes, runs the tokenizer states and bundles each item's events.
module htt_front import htt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  localparam int MaxPass = 4;

  typedef enum logic [13:0] {
    SData        = 14'h0001,
    STagOpen     = 14'h0002,
    SEndOpen     = 14'h0004,
    STagName     = 14'h0008,
    SBeforeAname = 14'h0010,
    SAname       = 14'h0020,
    SAfterAname  = 14'h0040,
    SBeforeAval  = 14'h0080,
    SAvalDq      = 14'h0100,
    SAvalSq      = 14'h0200,
    SAvalUnq     = 14'h0400,
    SAfterAvalQ  = 14'h0800,
    SSelfClose   = 14'h1000,
    SComment     = 14'h2000
  } st_e;

  typedef struct packed {
    logic [IdxW:0]      n;
    event_t [NumEv-1:0] ev;
  } acc_t;

  typedef struct packed {
    st_e  st;
    logic pend;
    acc_t acc;
  } step_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == ChTab || c == ChLf || c == ChFf || c == ChSpace;
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return is_upper(c) ? c + 8'd32 : c;
  endfunction

  function automatic acc_t put_f(acc_t a, ev_kind_e kind, logic [7:0] data, logic na,
                                 logic sc, logic [3:0] err);
    acc_t r;
    r = a;
    if (a.n < (IdxW+1)'(NumEv)) begin
      r.ev[a.n[IdxW-1:0]] = '{kind: kind, data: data, new_attr: na, self_close: sc, err: err};
      r.n = a.n + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t put_ev(acc_t a, ev_kind_e kind, logic [7:0] data);
    return put_f(a, kind, data, 1'b0, 1'b0, ErrNone);
  endfunction

  function automatic acc_t put_err(acc_t a, err_e code);
    return put_f(a, EvErr, 8'h00, 1'b0, 1'b0, code);
  endfunction

  function automatic step_t step_f(st_e st_in, logic pend_in, logic [7:0] c, logic eof);
    step_t r;
    logic  again;
    int    p;
    r.st     = st_in;
    r.pend   = pend_in;
    r.acc.n  = '0;
    r.acc.ev = '0;
    again    = 1'b1;
    for (p = 0; p < MaxPass; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (r.st)
          STagOpen: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofBeforeName);
              r.acc = put_ev(r.acc, EvChar, ChLt);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (c == ChBang) begin
              r.st = SComment;
            end else if (c == ChSlash) begin
              r.st = SEndOpen;
            end else if (is_alpha(c)) begin
              r.acc = put_ev(r.acc, EvStart, 8'h00);
              r.pend = 1'b0; r.st = STagName; again = 1'b1;
            end else if (c == ChQuest) begin
              r.acc = put_err(r.acc, ErrQuestion);
              r.st = SComment; again = 1'b1;
            end else begin
              r.acc = put_err(r.acc, ErrInvFirstChar);
              r.acc = put_ev(r.acc, EvChar, ChLt);
              r.st = SData; again = 1'b1;
            end
          end
          SEndOpen: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofBeforeName);
              r.acc = put_ev(r.acc, EvChar, ChLt);
              r.acc = put_ev(r.acc, EvChar, ChSlash);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (is_alpha(c)) begin
              r.acc = put_ev(r.acc, EvEnd, 8'h00);
              r.pend = 1'b0; r.st = STagName; again = 1'b1;
            end else if (c == ChGt) begin
              r.acc = put_err(r.acc, ErrMissingEndName);
              r.st = SData;
            end else begin
              r.acc = put_err(r.acc, ErrInvFirstChar);
              r.st = SComment; again = 1'b1;
            end
          end
          STagName: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (is_ws(c)) begin
              r.st = SBeforeAname;
            end else if (c == ChSlash) begin
              r.st = SSelfClose;
            end else if (c == ChGt) begin
              r.acc = put_ev(r.acc, EvClose, 8'h00);
              r.st = SData;
            end else begin
              r.acc = put_ev(r.acc, EvName, lower(c));
            end
          end
          SBeforeAname: begin
            if (eof || c == ChSlash || c == ChGt) begin
              r.st = SAfterAname; again = 1'b1;
            end else if (is_ws(c)) begin
              r.st = SBeforeAname;
            end else if (c == ChEq) begin
              r.acc = put_err(r.acc, ErrEqBeforeAname);
              r.acc = put_f(r.acc, EvAname, ChEq, 1'b1, 1'b0, ErrNone);
              r.pend = 1'b0; r.st = SAname;
            end else begin
              r.pend = 1'b1; r.st = SAname; again = 1'b1;
            end
          end
          SAname: begin
            if (eof || is_ws(c) || c == ChSlash || c == ChGt) begin
              r.st = SAfterAname; again = 1'b1;
            end else if (c == ChEq) begin
              r.st = SBeforeAval;
            end else begin
              if (c == ChDquote || c == ChSquote || c == ChLt) begin
                r.acc = put_err(r.acc, ErrCharInAname);
              end
              r.acc = put_f(r.acc, EvAname, lower(c), r.pend, 1'b0, ErrNone);
              r.pend = 1'b0;
            end
          end
          SAfterAname: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (is_ws(c)) begin
              r.st = SAfterAname;
            end else if (c == ChSlash) begin
              r.st = SSelfClose;
            end else if (c == ChEq) begin
              r.st = SBeforeAval;
            end else if (c == ChGt) begin
              r.acc = put_ev(r.acc, EvClose, 8'h00);
              r.st = SData;
            end else begin
              r.pend = 1'b1; r.st = SAname; again = 1'b1;
            end
          end
          SBeforeAval: begin
            if (eof) begin
              r.st = SAvalUnq; again = 1'b1;
            end else if (is_ws(c)) begin
              r.st = SBeforeAval;
            end else if (c == ChDquote) begin
              r.st = SAvalDq;
            end else if (c == ChSquote) begin
              r.st = SAvalSq;
            end else if (c == ChGt) begin
              r.acc = put_err(r.acc, ErrMissingAval);
              r.acc = put_ev(r.acc, EvClose, 8'h00);
              r.st = SData;
            end else begin
              r.st = SAvalUnq; again = 1'b1;
            end
          end
          SAvalDq, SAvalSq: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (c == ((r.st == SAvalDq) ? ChDquote : ChSquote)) begin
              r.st = SAfterAvalQ;
            end else begin
              r.acc = put_ev(r.acc, EvAval, c);
            end
          end
          SAvalUnq: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (is_ws(c)) begin
              r.st = SBeforeAname;
            end else if (c == ChGt) begin
              r.acc = put_ev(r.acc, EvClose, 8'h00);
              r.st = SData;
            end else begin
              if (c == ChDquote || c == ChSquote || c == ChLt || c == ChEq || c == ChBtick) begin
                r.acc = put_err(r.acc, ErrCharInUnqAval);
              end
              r.acc = put_ev(r.acc, EvAval, c);
            end
          end
          SAfterAvalQ: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (is_ws(c)) begin
              r.st = SBeforeAname;
            end else if (c == ChSlash) begin
              r.st = SSelfClose;
            end else if (c == ChGt) begin
              r.acc = put_ev(r.acc, EvClose, 8'h00);
              r.st = SData;
            end else begin
              r.acc = put_err(r.acc, ErrMissingWs);
              r.st = SBeforeAname; again = 1'b1;
            end
          end
          SSelfClose: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInTag);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (c == ChGt) begin
              r.acc = put_f(r.acc, EvClose, 8'h00, 1'b0, 1'b1, ErrNone);
              r.st = SData;
            end else begin
              r.acc = put_err(r.acc, ErrSolidusInTag);
              r.st = SBeforeAname; again = 1'b1;
            end
          end
          SComment: begin
            if (eof) begin
              r.acc = put_err(r.acc, ErrEofInComment);
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.st = SData; r.pend = 1'b0;
            end else if (c == ChGt) begin
              r.st = SData;
            end
          end
          default: begin
            if (eof) begin
              r.acc = put_ev(r.acc, EvEof, 8'h00);
              r.pend = 1'b0;
            end else if (c == ChLt) begin
              r.st = STagOpen;
            end else begin
              r.acc = put_ev(r.acc, EvChar, c);
            end
            if (!(!eof && c == ChLt)) begin
              r.st = SData;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  st_e   st_q, st_d;
  logic  pend_q, pend_d;
  step_t res;
  logic  accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    res    = step_f(st_q, pend_q, in_byte_i, end_of_input_i);
    st_d   = accept ? res.st : st_q;
    pend_d = accept ? res.pend : pend_q;
  end

  assign q_push_o       = accept && (res.acc.n != '0);
  assign q_entry_o.ev   = res.acc.ev;
  assign q_entry_o.last = IdxW'(res.acc.n - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SData;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
    end
  end

endmodule

@@ rtl/htt_queue.sv @@
// Two-entry queue of event bundles between the front and back ends.
module htt_queue import htt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t entry_o,
  input  logic   pop_i
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/htt_back.sv @@
// Back end: walks bundles, one event per cycle to the output register unless stalled.
module htt_back import htt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] event_kind_o,
  output logic [7:0] event_byte_o,
  output logic       new_attribute_o,
  output logic       self_closing_o,
  output logic [3:0] error_code_o,
  output logic       last_of_step_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  event_t          ev_q;
  logic            last_q;
  logic            load;
  logic            at_last;

  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign at_last = idx_q == q_entry_i.last;
  assign q_pop_o = load && at_last;

  always_comb begin
    valid_d = load || (valid_q && out_stall_i);
    idx_d   = idx_q;
    if (load) begin
      idx_d = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q   <= q_entry_i.ev[idx_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o     = valid_q;
  assign event_kind_o    = ev_q.kind;
  assign event_byte_o    = ev_q.data;
  assign new_attribute_o = ev_q.new_attr;
  assign self_closing_o  = ev_q.self_close;
  assign error_code_o    = ev_q.err;
  assign last_of_step_o  = last_q;

endmodule

@@ rtl/html_tag_tokenizer_core.sv @@
// Top level of the HTML tag tokenizer: front end, event queue and back end.
// An accepted byte's first event is written into the queue and then into the output register.
// Throughput: one byte per cycle at the input while the queue is not full; the output issues
// one event per cycle while not stalled, so a byte that causes k events holds the back end until all k are issued.
// A byte that causes no event passes the front end alone and takes no queue slot.
// Reset: asynchronous, active low; returns to the data state and empties queue and output.
module html_tag_tokenizer_core import htt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] event_kind_o,
  output logic [7:0] event_byte_o,
  output logic       new_attribute_o,
  output logic       self_closing_o,
  output logic [3:0] error_code_o,
  output logic       last_of_step_o
);

  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  entry_t q_wr_entry;
  entry_t q_rd_entry;

  htt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_wr_entry)
  );

  htt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_rd_entry),
    .pop_i   (q_pop)
  );

  htt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_rd_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .event_byte_o    (event_byte_o),
    .new_attribute_o (new_attribute_o),
    .self_closing_o  (self_closing_o),
    .error_code_o    (error_code_o),
    .last_of_step_o  (last_of_step_o)
  );

endmodule
